### rtl/ssd_pkg.sv
package ssd_pkg;

  // Pin levels for one result beat
  typedef struct packed {
    logic latch_clock;
    logic shift_clock;
    logic serial_data;
  } ssd_pins_t;

  // Item kinds carried on tuser
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [15:0] DWELL_RESET = 16'd3000;
  localparam logic [13:0] VALUE_MAX   = 14'd9999;
  localparam logic [7:0]  SEL_LEFT    = 8'h08;
  localparam logic [7:0]  SEG_BLANK   = 8'hFF;

  // Common-anode segment pattern, active low
  function automatic logic [7:0] seg_lut(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

### rtl/seven_segment_scan_shift_driver_top.sv
// A tick beat is held in the input register, then gives its result beat in the result register.
// Throughput: one beat per cycle while the result slot is free; the scan state register closes the loop.
// Load beats give no result and take effect before the next beat in order.
// Reset (rst_n low at a clock edge) clears the pipeline, shows 0000, restarts
// the scan at the leftmost digit and sets the dwell to 3000 ticks.
module seven_segment_scan_shift_driver_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,    // dwell_ticks
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [13:0] value, [15:14] zero
  input  logic [0:0]  in_tuser,     // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata     // [0] serial_data, [1] shift_clock,
                                    // [2] latch_clock, [7:3] zero
);
  import ssd_pkg::*;

  logic        in_vld_r;
  logic        in_kind_r;
  logic [13:0] in_value_r;
  logic [15:0] dwell_ticks_r;
  logic        out_vld_r;
  ssd_pins_t   out_pins_r;

  logic        slot_free;
  logic        fire;
  logic        load_en;
  logic        tick_en;
  logic [15:0] bcd;
  ssd_pins_t   pins;

  // A tick needs a free result slot, a load never waits
  assign slot_free = !out_vld_r || out_tready;
  assign fire      = in_vld_r && ((in_kind_r == KIND_LOAD) || slot_free);
  assign load_en   = fire && (in_kind_r == KIND_LOAD);
  assign tick_en   = fire && (in_kind_r == KIND_TICK);
  assign in_tready = !in_vld_r || fire;

  // Hold the dwell setting
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_ticks_r <= DWELL_RESET;
    end else if (cfg_wen) begin
      dwell_ticks_r <= cfg_wdata;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_kind_r  <= in_tuser[0];
      in_value_r <= in_tdata[13:0];
    end
  end

  ssd_bcd u_bcd (
    .value  (in_value_r),
    .digits (bcd)
  );

  ssd_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_en     (load_en),
    .load_digits (bcd),
    .tick_en     (tick_en),
    .dwell_ticks (dwell_ticks_r),
    .pins        (pins)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (slot_free) begin
      out_vld_r <= tick_en;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_en) begin
      out_pins_r <= pins;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'b0, out_pins_r.latch_clock, out_pins_r.shift_clock,
                       out_pins_r.serial_data};

endmodule

### rtl/ssd_bcd.sv
module ssd_bcd (
  input  logic [13:0] value,
  output logic [15:0] digits
);
  import ssd_pkg::*;

  logic [13:0] v;
  logic [28:0] p1000;
  logic [27:0] p100;
  logic [27:0] p10;
  logic [3:0]  q1000;
  logic [6:0]  q100;
  logic [9:0]  q10;
  logic [13:0] d2_w;
  logic [13:0] d1_w;
  logic [13:0] d0_w;

  // Saturate to four digits
  assign v = (value > VALUE_MAX) ? VALUE_MAX : value;

  // Quotients by reciprocal multiply, exact for v below 10000
  assign p1000 = 29'(v) * 29'd16778;
  assign p100  = 28'(v) * 28'd10486;
  assign p10   = 28'(v) * 28'd13108;
  assign q1000 = p1000[27:24];
  assign q100  = p100[26:20];
  assign q10   = p10[26:17];

  // Each digit is a quotient less ten times the next coarser one
  assign d2_w = 14'(q100) - 14'(q1000) * 14'd10;
  assign d1_w = 14'(q10)  - 14'(q100)  * 14'd10;
  assign d0_w = v         - 14'(q10)   * 14'd10;

  assign digits = {q1000, d2_w[3:0], d1_w[3:0], d0_w[3:0]};

endmodule

### rtl/ssd_scan.sv
module ssd_scan (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load_en,
  input  logic [15:0]      load_digits,
  input  logic             tick_en,
  input  logic [15:0]      dwell_ticks,
  output ssd_pkg::ssd_pins_t pins
);
  import ssd_pkg::*;

  typedef enum logic [2:0] {
    PH_DATA  = 3'd0,
    PH_CLKHI = 3'd1,
    PH_LATLO = 3'd2,
    PH_LATHI = 3'd3,
    PH_DWELL = 3'd4
  } phase_t;

  logic [15:0] digits_r;
  logic [1:0]  pos_r,   pos_nxt;
  logic [3:0]  bit_r,   bit_nxt;
  phase_t      phase_r, phase_nxt;
  logic [15:0] dwell_r, dwell_nxt;

  logic [3:0]  cur_digit;
  logic [7:0]  seg;
  logic [7:0]  sel;
  logic [15:0] frame;
  logic        frame_bit;
  logic [15:0] dwell_inc;

  // Pick the frame bit of the current digit, MSB first
  always_comb begin
    case (pos_r)
      2'd0:    cur_digit = digits_r[15:12];
      2'd1:    cur_digit = digits_r[11:8];
      2'd2:    cur_digit = digits_r[7:4];
      default: cur_digit = digits_r[3:0];
    endcase
    seg       = seg_lut(cur_digit);
    sel       = SEL_LEFT >> pos_r;
    frame     = {seg, sel};
    frame_bit = frame[~bit_r];
    dwell_inc = (dwell_r < dwell_ticks) ? dwell_r + 16'd1 : dwell_r;
  end

  // Step the pin sequence for one tick
  always_comb begin
    pos_nxt   = pos_r;
    bit_nxt   = bit_r;
    phase_nxt = phase_r;
    dwell_nxt = dwell_r;
    pins      = '{latch_clock: 1'b1, shift_clock: 1'b0, serial_data: 1'b0};
    case (phase_r)
      PH_DATA: begin
        pins.serial_data = frame_bit;
        phase_nxt        = PH_CLKHI;
      end
      PH_CLKHI: begin
        pins.serial_data = frame_bit;
        pins.shift_clock = 1'b1;
        if (bit_r == 4'd15) begin
          bit_nxt   = '0;
          phase_nxt = PH_LATLO;
        end else begin
          bit_nxt   = bit_r + 4'd1;
          phase_nxt = PH_DATA;
        end
      end
      PH_LATLO: begin
        pins.latch_clock = 1'b0;
        phase_nxt        = PH_LATHI;
      end
      PH_LATHI: begin
        dwell_nxt = '0;
        if (dwell_ticks == 16'd0) begin
          pos_nxt   = pos_r + 2'd1;
          bit_nxt   = '0;
          phase_nxt = PH_DATA;
        end else begin
          phase_nxt = PH_DWELL;
        end
      end
      PH_DWELL: begin
        dwell_nxt = dwell_inc;
        if (dwell_inc >= dwell_ticks) begin
          pos_nxt   = pos_r + 2'd1;
          bit_nxt   = '0;
          phase_nxt = PH_DATA;
          dwell_nxt = '0;
        end
      end
      default: begin
        // Unreachable codes behave as data phase at frame bit zero
        pins.serial_data = frame[15];
        bit_nxt          = '0;
        phase_nxt        = PH_CLKHI;
      end
    endcase
  end

  // Hold scan state; a load restarts at the leftmost digit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r <= '0;
      pos_r    <= '0;
      bit_r    <= '0;
      phase_r  <= PH_DATA;
      dwell_r  <= '0;
    end else if (load_en) begin
      digits_r <= load_digits;
      pos_r    <= '0;
      bit_r    <= '0;
      phase_r  <= PH_DATA;
      dwell_r  <= '0;
    end else if (tick_en) begin
      pos_r    <= pos_nxt;
      bit_r    <= bit_nxt;
      phase_r  <= phase_nxt;
      dwell_r  <= dwell_nxt;
    end
  end

endmodule
